/* hw/rtl/gng_pkg.sv */
// gng_pkg: shared constants, types and helper functions of the gaussian noise generator
// no dependencies
package gng_pkg;

  localparam int unsigned SAMPLE_FRAC_BITS = 11;
  localparam int unsigned SCALE_SHIFT      = 54 - SAMPLE_FRAC_BITS;
  localparam int unsigned SAMPLE_W         = 16;

  localparam logic [63:0] SEED_RESET = 64'd1;
  localparam logic [63:0] SEED_XOR   = 64'hDEAD_BEEF;
  localparam logic [30:0] LN2X2_Q30  = 31'd1488522236;
  localparam logic [31:0] PI_Q30     = 32'hC90F_DAA2;
  localparam logic [27:0] R_MAX_Q24  = '1;
  localparam logic [3:0]  LAST_SIN_K = 4'd4;
  localparam logic [3:0]  LAST_K     = 4'd9;

  typedef struct packed {
    logic valid;
    logic reload;
  } gng_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GEN1,
    ST_GEN2,
    ST_NORM,
    ST_LOG,
    ST_RAD,
    ST_SQRT,
    ST_ANG,
    ST_X2,
    ST_TMUL,
    ST_TDIV,
    ST_TFIX,
    ST_SEL,
    ST_SCALE_C,
    ST_SCALE_S
  } gng_state_e;

  // factorial step divisors: sine terms first, then cosine terms
  function automatic logic [6:0] gng_divisor(input logic [3:0] k);
    logic [6:0] d;
    case (k)
      4'd0:    d = 7'd6;
      4'd1:    d = 7'd20;
      4'd2:    d = 7'd42;
      4'd3:    d = 7'd72;
      4'd4:    d = 7'd110;
      4'd5:    d = 7'd2;
      4'd6:    d = 7'd12;
      4'd7:    d = 7'd30;
      4'd8:    d = 7'd56;
      4'd9:    d = 7'd90;
      default: d = 7'd1;
    endcase
    return d;
  endfunction

  // floor(2^32 / divisor) for the same step order
  function automatic logic [31:0] gng_recip(input logic [3:0] k);
    logic [31:0] m;
    case (k)
      4'd0:    m = 32'd715827882;
      4'd1:    m = 32'd214748364;
      4'd2:    m = 32'd102261126;
      4'd3:    m = 32'd59652323;
      4'd4:    m = 32'd39045157;
      4'd5:    m = 32'd2147483648;
      4'd6:    m = 32'd357913941;
      4'd7:    m = 32'd143165576;
      4'd8:    m = 32'd76695844;
      4'd9:    m = 32'd47721858;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  // r (q.24) times trig (q.30), rounded half away from zero, saturated
  function automatic logic [SAMPLE_W-1:0] gng_scale(input logic [27:0] r,
                                                   input logic signed [31:0] trig);
    logic        neg;
    logic [31:0] mag;
    logic [60:0] sum;
    logic [60:0] q;
    neg = trig[31];
    mag = neg ? 32'(-trig) : 32'(trig);
    sum = 61'(r) * 61'(mag) + (61'd1 << (SCALE_SHIFT - 1));
    q   = sum >> SCALE_SHIFT;
    if (neg) begin
      if (q > 61'd32768) q = 61'd32768;
      return SAMPLE_W'(61'd0 - q);
    end
    if (q > 61'd32767) q = 61'd32767;
    return SAMPLE_W'(q);
  endfunction

endpackage

/* hw/rtl/gng_req_if.sv */
// gng_req_if: request channel, one word per sample request
// depends on nothing
interface gng_req_if;
  logic valid;
  logic ready;
  logic reload;
  modport source (output valid, output reload, input ready);
  modport sink (input valid, input reload, output ready);
endinterface

/* hw/rtl/gng_smp_if.sv */
// gng_smp_if: sample channel, one word per normal sample
// depends on gng_pkg
interface gng_smp_if;
  logic                          valid;
  logic                          ready;
  logic [gng_pkg::SAMPLE_W-1:0]  sample;
  logic                          from_sine;
  modport source (output valid, output sample, output from_sine, input ready);
  modport sink (input valid, input sample, input from_sine, output ready);
endinterface

/* hw/rtl/gng_front.sv */
// gng_front: request intake, two-word queue of reload flags
// depends on gng_pkg, gng_req_if
module gng_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  gng_req_if.sink           req,
  input  logic              pop_i,
  output gng_pkg::gng_cmd_t cmd_o
);
  import gng_pkg::*;

  logic [1:0] buf_q;
  logic [1:0] buf_d;
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;

  assign req.ready    = (cnt_q != 2'd2);
  assign push         = req.valid && req.ready;
  assign cmd_o.valid  = (cnt_q != 2'd0);
  assign cmd_o.reload = buf_q[rd_q];

  always_comb begin
    buf_d = buf_q;
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      buf_d[wr_q] = req.reload;
      wr_d        = ~wr_q;
    end
    if (pop_i) rd_d = ~rd_q;
    if (push && !pop_i) cnt_d = cnt_q + 2'd1;
    else if (!push && pop_i) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

endmodule

/* hw/rtl/gng_core.sv */
// gng_core: generator state, box-muller sequencer and output register
// depends on gng_pkg, gng_smp_if
module gng_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [63:0]       seed_i,
  input  gng_pkg::gng_cmd_t cmd_i,
  output logic              pop_o,
  gng_smp_if.source         smp
);
  import gng_pkg::*;

  gng_state_e state_q, state_d;

  logic [63:0] lo_q, lo_d, hi_q, hi_d;
  logic [SAMPLE_W-1:0] held_q, held_d;
  logic        have_held_q, have_held_d;
  logic        out_valid_q, out_valid_d;
  logic [SAMPLE_W-1:0] out_sample_q, out_sample_d;
  logic        out_sine_q, out_sine_d;

  logic [52:0] a_q, a_d;
  logic        azero_q, azero_d;
  logic [5:0]  nz_q, nz_d;
  logic [31:0] p_q, p_d;
  logic [31:0] m_q, m_d;
  logic [23:0] frac_q, frac_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [54:0] sqn_q, sqn_d, sres_q, sres_d, sbit_q, sbit_d;
  logic [27:0] r_q, r_d;
  logic [29:0] alpha_q, alpha_d, x2_q, x2_d;
  logic [30:0] term_q, term_d;
  logic [29:0] dq_q, dq_d;
  logic [29:0] quo_q, quo_d;
  logic [3:0]  k_q, k_d;
  logic signed [31:0] acc_s_q, acc_s_d, acc_c_q, acc_c_d;
  logic signed [31:0] cos_q, cos_d, sin_q, sin_d;

  logic [63:0] gx, gnh, gword;
  logic [63:0] sq;
  logic [32:0] sqs;
  logic [29:0] nl;
  logic [60:0] vprod;
  logic [55:0] ssum;
  logic [54:0] sres_nxt;
  logic [29:0] tp;
  logic [61:0] aprod;
  logic [59:0] x2p;
  logic [60:0] tprod;
  logic [6:0]  dvs;
  logic [31:0] rcp;
  logic [61:0] qprod;
  logic [36:0] qd;
  logic [29:0] rdiff;
  logic [29:0] qfix;
  logic signed [31:0] dterm, sb, cb;
  logic signed [31:0] scale_in;
  logic [SAMPLE_W-1:0] scaled;

  assign smp.valid     = out_valid_q;
  assign smp.sample    = out_sample_q;
  assign smp.from_sine = out_sine_q;

  // xorshift128+ step
  assign gx    = lo_q ^ (lo_q << 23);
  assign gnh   = gx ^ hi_q ^ (gx >> 17) ^ (hi_q >> 26);
  assign gword = gnh + hi_q;

  assign scale_in = (state_q == ST_SCALE_C) ? cos_q : sin_q;
  assign scaled   = gng_scale(r_q, scale_in);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_i.valid && !out_valid_q && (cmd_i.reload || !have_held_q)) state_d = ST_GEN1;
      end
      ST_GEN1: state_d = ST_GEN2;
      ST_GEN2: state_d = ST_NORM;
      ST_NORM: begin
        if (azero_q) state_d = ST_ANG;
        else if (a_q[52]) state_d = ST_LOG;
      end
      ST_LOG:  if (cnt_q == 5'd23) state_d = ST_RAD;
      ST_RAD:  state_d = ST_SQRT;
      ST_SQRT: if (sbit_q[0]) state_d = ST_ANG;
      ST_ANG:  state_d = ST_X2;
      ST_X2:   state_d = ST_TMUL;
      ST_TMUL: state_d = ST_TDIV;
      ST_TDIV: state_d = ST_TFIX;
      ST_TFIX: state_d = (k_q == LAST_K) ? ST_SEL : ST_TMUL;
      ST_SEL:     state_d = ST_SCALE_C;
      ST_SCALE_C: state_d = ST_SCALE_S;
      ST_SCALE_S: state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    lo_d = lo_q; hi_d = hi_q;
    held_d = held_q; have_held_d = have_held_q;
    out_valid_d = out_valid_q; out_sample_d = out_sample_q; out_sine_d = out_sine_q;
    a_d = a_q; azero_d = azero_q; nz_d = nz_q; p_d = p_q;
    m_d = m_q; frac_d = frac_q; cnt_d = cnt_q;
    sqn_d = sqn_q; sres_d = sres_q; sbit_d = sbit_q; r_d = r_q;
    alpha_d = alpha_q; x2_d = x2_q; term_d = term_q; dq_d = dq_q; quo_d = quo_q;
    k_d = k_q; acc_s_d = acc_s_q; acc_c_d = acc_c_q; cos_d = cos_q; sin_d = sin_q;
    pop_o = 1'b0;
    sq = 64'(m_q) * 64'(m_q);
    sqs = sq[63:31];
    nl = {nz_q + 6'd1, 24'd0} - {6'd0, frac_q};
    vprod = 61'(nl) * 61'(LN2X2_Q30);
    ssum = {1'b0, sres_q} + {1'b0, sbit_q};
    sres_nxt = sres_q >> 1;
    tp = p_q[29] ? (30'd1 << 29) - {1'b0, p_q[28:0]} : {1'b0, p_q[28:0]};
    aprod = 62'(tp) * 62'(PI_Q30);
    x2p = 60'(alpha_q) * 60'(alpha_q);
    tprod = 61'(term_q) * 61'(x2_q);
    dvs = gng_divisor(k_q);
    rcp = gng_recip(k_q);
    qprod = 62'(dq_q) * 62'(rcp);
    qd = 37'(quo_q) * 37'(dvs);
    rdiff = dq_q - qd[29:0];
    qfix = (rdiff >= 30'(dvs)) ? quo_q + 30'd1 : quo_q;
    dterm = 32'(qfix);
    sb = p_q[29] ? acc_c_q : acc_s_q;
    cb = p_q[29] ? acc_s_q : acc_c_q;

    if (smp.valid && smp.ready) out_valid_d = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (cmd_i.valid && !out_valid_q) begin
          pop_o = 1'b1;
          if (cmd_i.reload) begin
            lo_d        = seed_i;
            hi_d        = seed_i ^ SEED_XOR;
            have_held_d = 1'b0;
          end else if (have_held_q) begin
            out_sample_d = held_q;
            out_sine_d   = 1'b1;
            out_valid_d  = 1'b1;
            have_held_d  = 1'b0;
          end
        end
      end
      ST_GEN1: begin
        a_d  = gword[63:11];
        lo_d = hi_q;
        hi_d = gnh;
      end
      ST_GEN2: begin
        p_d     = gword[63:32];
        lo_d    = hi_q;
        hi_d    = gnh;
        azero_d = (a_q == '0);
        nz_d    = 6'd0;
      end
      ST_NORM: begin
        if (azero_q) begin
          r_d = R_MAX_Q24;
        end else if (a_q[52]) begin
          m_d    = a_q[52:21];
          cnt_d  = 5'd0;
          frac_d = 24'd0;
        end else begin
          a_d  = a_q << 1;
          nz_d = nz_q + 6'd1;
        end
      end
      ST_LOG: begin
        // one squaring per cycle gives one fraction bit of log2
        if (sqs[32]) begin
          m_d    = sqs[32:1];
          frac_d = {frac_q[22:0], 1'b1};
        end else begin
          m_d    = sqs[31:0];
          frac_d = {frac_q[22:0], 1'b0};
        end
        cnt_d = cnt_q + 5'd1;
      end
      ST_RAD: begin
        sqn_d  = {vprod[60:30], 24'd0};
        sres_d = 55'd0;
        sbit_d = 55'd1 << 54;
      end
      ST_SQRT: begin
        if ({1'b0, sqn_q} >= ssum) begin
          sqn_d    = sqn_q - ssum[54:0];
          sres_nxt = (sres_q >> 1) + sbit_q;
        end
        sres_d = sres_nxt;
        sbit_d = sbit_q >> 2;
        if (sbit_q[0]) r_d = sres_nxt[27:0];
      end
      ST_ANG: begin
        alpha_d = aprod[60:31];
      end
      ST_X2: begin
        x2_d    = x2p[59:30];
        term_d  = 31'(alpha_q);
        acc_s_d = 32'(alpha_q);
        k_d     = 4'd0;
      end
      ST_TMUL: begin
        dq_d = tprod[59:30];
      end
      ST_TDIV: begin
        // reciprocal estimate, low by at most one
        quo_d = qprod[61:32];
      end
      ST_TFIX: begin
        term_d = {1'b0, qfix};
        if (k_q <= LAST_SIN_K) begin
          acc_s_d = k_q[0] ? acc_s_q + dterm : acc_s_q - dterm;
        end else begin
          acc_c_d = k_q[0] ? acc_c_q - dterm : acc_c_q + dterm;
        end
        if (k_q == LAST_SIN_K) begin
          term_d  = 31'd1 << 30;
          acc_c_d = 32'sd1 <<< 30;
        end
        k_d = k_q + 4'd1;
      end
      ST_SEL: begin
        case (p_q[31:30])
          2'd0: begin cos_d = cb;  sin_d = sb;  end
          2'd1: begin cos_d = -sb; sin_d = cb;  end
          2'd2: begin cos_d = -cb; sin_d = -sb; end
          default: begin cos_d = sb; sin_d = -cb; end
        endcase
      end
      ST_SCALE_C: begin
        out_sample_d = scaled;
        out_sine_d   = 1'b0;
        out_valid_d  = 1'b1;
      end
      ST_SCALE_S: begin
        held_d      = scaled;
        have_held_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      lo_q        <= SEED_RESET;
      hi_q        <= SEED_RESET ^ SEED_XOR;
      held_q      <= '0;
      have_held_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      held_q      <= held_d;
      have_held_q <= have_held_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_sample_q <= out_sample_d;
    out_sine_q   <= out_sine_d;
    a_q     <= a_d;
    azero_q <= azero_d;
    nz_q    <= nz_d;
    p_q     <= p_d;
    m_q     <= m_d;
    frac_q  <= frac_d;
    cnt_q   <= cnt_d;
    sqn_q   <= sqn_d;
    sres_q  <= sres_d;
    sbit_q  <= sbit_d;
    r_q     <= r_d;
    alpha_q <= alpha_d;
    x2_q    <= x2_d;
    term_q  <= term_d;
    dq_q    <= dq_d;
    quo_q   <= quo_d;
    k_q     <= k_d;
    acc_s_q <= acc_s_d;
    acc_c_q <= acc_c_d;
    cos_q   <= cos_d;
    sin_q   <= sin_d;
  end

endmodule

/* hw/rtl/gaussian_noise_generator.sv */
// gaussian_noise_generator: top level, seed register, request queue and sample engine
// depends on gng_pkg, gng_req_if, gng_smp_if, gng_front, gng_core
//
// usage:
//   req channel: one word per request; reload=1 reloads the xorshift128+
//     state from the seed register and drops any held sine sample
//   smp channel: one word per request, a signed 16-bit normal sample with
//     SAMPLE_FRAC_BITS fraction bits and from_sine marking the held half
//   cfg port: cfg_we_i writes cfg_wdata_i into the seed register; the
//     generator only picks it up on a reload
// steps:
//   a request that draws a new pair runs through two generator steps, up to
//   52 normalize shifts, 24 log squarings, 28 square-root steps and ten
//   series terms, each a multiply, a reciprocal divide and a correction;
//   when u1 is zero the log and square-root steps are skipped
//   a request served from the held sine half shows its sample the next cycle
// the engine works on one request at a time and, after the cosine sample, stores
// the sine half; a two-word request queue keeps accepting while the engine is
// busy, and the output register holds a finished sample while the receiver
// stalls (the engine waits for it to drain before starting the next request)
// reset: seed 1, generator loaded from it, nothing held, queue empty
module gaussian_noise_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_wdata_i,
  gng_req_if.sink     req,
  gng_smp_if.source   smp
);
  import gng_pkg::*;

  logic [63:0] seed_q;
  gng_cmd_t    cmd;
  logic        pop;

  // seed register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= SEED_RESET;
    end else if (cfg_we_i) begin
      seed_q <= cfg_wdata_i;
    end
  end

  // request intake queue
  gng_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req),
    .pop_i  (pop),
    .cmd_o  (cmd)
  );

  // box-muller sequencer and output register
  gng_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .seed_i (seed_q),
    .cmd_i  (cmd),
    .pop_o  (pop),
    .smp    (smp)
  );

endmodule

/* hw/rtl/gng_checker.sv */
// gng_checker: port-level checks of the gaussian noise generator, bound to the top level
// depends on gng_pkg, gaussian_noise_generator
module gng_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         req_valid_i,
  input logic                         req_ready_i,
  input logic                         smp_valid_i,
  input logic                         smp_ready_i,
  input logic [gng_pkg::SAMPLE_W-1:0] smp_sample_i,
  input logic                         smp_from_sine_i
);
  import gng_pkg::*;

  logic [2:0] pend_q, pend_d;
  logic       cos_seen_q, cos_seen_d;
  logic       in_acc, out_acc;

  assign in_acc  = req_valid_i && req_ready_i;
  assign out_acc = smp_valid_i && smp_ready_i;

  always_comb begin
    pend_d     = pend_q + 3'(in_acc) - 3'(out_acc);
    cos_seen_d = cos_seen_q;
    if (out_acc) cos_seen_d = !smp_from_sine_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q     <= 3'd0;
      cos_seen_q <= 1'b0;
    end else begin
      pend_q     <= pend_d;
      cos_seen_q <= cos_seen_d;
    end
  end

  // stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    smp_valid_i && !smp_ready_i |=> smp_valid_i && $stable(smp_sample_i)
      && $stable(smp_from_sine_i))
    else $error("sample word changed while stalled");

  // no sample without an outstanding request
  a_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    smp_valid_i |-> pend_q != 3'd0)
    else $error("sample without request");

  // sine half only right after its cosine half
  a_sine: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && smp_from_sine_i |-> cos_seen_q)
    else $error("sine half without preceding cosine half");

  // back-pressure only when at least two requests are outstanding
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_ready_i |-> pend_q >= 3'd2)
    else $error("request stalled with room in queue");

endmodule

bind gaussian_noise_generator gng_checker u_gng_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req.valid),
  .req_ready_i     (req.ready),
  .smp_valid_i     (smp.valid),
  .smp_ready_i     (smp.ready),
  .smp_sample_i    (smp.sample),
  .smp_from_sine_i (smp.from_sine)
);
